// ----- src/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace core: register
// indexes, item codes, and the result bundle passed from the match logic.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// Default for the longest pattern the hold buffer supports.
	localparam int MAX_PATTERN_DEF = 8;

	// Replacement text is fixed at up to eight bytes by its register.
	localparam int REPL_MAX = 8;

	// One input item causes at most this many output bytes.
	localparam int RES_DEPTH = 8;
	localparam int RES_CNT_W = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES      = 2'd0,
		CFG_PATTERN_LENGTH     = 2'd1,
		CFG_REPLACEMENT_BYTES  = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_idx_t;

	// Item kinds and the line break character.
	localparam logic  KIND_DATA  = 1'b0;
	localparam logic  KIND_FLUSH = 1'b1;
	localparam logic [7:0] NEWLINE = 8'd10;

	typedef logic [7:0] byte_t;

	// Output bytes caused by one item, byte 0 goes out first.
	typedef struct packed {
		logic [RES_CNT_W-1:0]     count;
		byte_t [RES_DEPTH-1:0]    bytes;
	} result_t;

endpackage

// ----- src/sfr_in_if.sv -----
// ----------------------------------------------------------------------------
// sfr_in_if
// Input stream channel: one text byte or a flush marker per transaction.
// ----------------------------------------------------------------------------
interface sfr_in_if;
	import sfr_pkg::*;

	logic  valid;
	logic  ready;
	logic  kind;
	byte_t data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
	modport mon    (input valid, input kind, input data_byte, input ready);

endinterface

// ----- src/sfr_out_if.sv -----
// ----------------------------------------------------------------------------
// sfr_out_if
// Output stream channel: one result byte per transaction, with a marker on
// the final byte caused by an input item.
// ----------------------------------------------------------------------------
interface sfr_out_if;
	import sfr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input last_of_run, output ready);
	modport mon    (input valid, input out_byte, input last_of_run, input ready);

endinterface

// ----- src/sfr_match.sv -----
// ----------------------------------------------------------------------------
// sfr_match
// Match and release logic for one item. Appends the byte to the held run,
// tests for a full match, and otherwise finds the shortest release after
// which the rest is still a proper prefix of the pattern.
// ----------------------------------------------------------------------------
module sfr_match #(
	parameter int MaxPattern = sfr_pkg::MAX_PATTERN_DEF,
	parameter int CntW       = $clog2(MaxPattern + 1)
) (
	input  logic                          kind,
	input  sfr_pkg::byte_t                data_byte,
	input  sfr_pkg::byte_t [MaxPattern-1:0] pend,
	input  logic [CntW-1:0]               pend_cnt,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] pat_bytes,
	input  logic [sfr_pkg::LEN_W-1:0]     pat_len,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] rep_bytes,
	input  logic [sfr_pkg::LEN_W-1:0]     rep_len,
	output sfr_pkg::result_t              res,
	output sfr_pkg::byte_t [MaxPattern-1:0] nxt_pend,
	output logic [CntW-1:0]               nxt_cnt
);
	import sfr_pkg::*;

	logic [LEN_W-1:0]          plen;
	logic [LEN_W-1:0]          rlen;
	byte_t [MaxPattern-1:0]    ext;
	logic [CntW-1:0]           cnt_ext;
	logic                      is_break;
	logic [MaxPattern:0]       ok;
	logic                      full_match;
	logic [CntW-1:0]           k_sel;
	logic [MaxPattern*8-1:0]   shifted;

	// Effective lengths: zero acts as one, large values saturate.
	always_comb begin
		if (pat_len == '0) begin
			plen = LEN_W'(1);
		end else if (pat_len > LEN_W'(MaxPattern)) begin
			plen = LEN_W'(MaxPattern);
		end else begin
			plen = pat_len;
		end
		if (rep_len == '0) begin
			rlen = LEN_W'(1);
		end else if (rep_len > LEN_W'(REPL_MAX)) begin
			rlen = LEN_W'(REPL_MAX);
		end else begin
			rlen = rep_len;
		end
	end

	// Held run with the new byte placed behind it.
	always_comb begin
		for (int i = 0; i < MaxPattern; i++) begin
			ext[i] = (CntW'(i) == pend_cnt) ? data_byte : pend[i];
		end
	end

	assign cnt_ext  = pend_cnt + CntW'(1);
	assign is_break = (kind == KIND_FLUSH) || (data_byte == NEWLINE);

	// For each release depth, test whether the remainder may stay held.
	always_comb begin
		int  rem;
		logic pre;
		for (int k = 0; k <= MaxPattern; k++) begin
			rem = int'(cnt_ext) - k;
			pre = 1'b1;
			for (int j = 0; j < MaxPattern; j++) begin
				if (j < rem) begin
					if (k + j >= MaxPattern) begin
						pre = 1'b0;
					end else if (ext[(k + j) % MaxPattern] != pat_bytes[8*j +: 8]) begin
						pre = 1'b0;
					end
				end
			end
			ok[k] = (rem >= 0) && ((rem == 0) || ((rem < int'(plen)) && pre));
		end
	end

	// A full match is tested on the whole run only.
	always_comb begin
		logic pre;
		pre = 1'b1;
		for (int j = 0; j < MaxPattern; j++) begin
			if (CntW'(j) < cnt_ext && ext[j] != pat_bytes[8*j +: 8]) begin
				pre = 1'b0;
			end
		end
		full_match = (LEN_W'(cnt_ext) == plen) && pre;
	end

	// Smallest release depth that leaves a valid held run.
	always_comb begin
		k_sel = cnt_ext;
		for (int k = MaxPattern; k >= 0; k--) begin
			if (ok[k]) begin
				k_sel = CntW'(k);
			end
		end
	end

	assign shifted = ext >> {k_sel, 3'b000};

	// Result bytes and next hold state.
	always_comb begin
		for (int i = 0; i < RES_DEPTH; i++) begin
			res.bytes[i] = (i < MaxPattern) ? ext[i % MaxPattern] : '0;
		end
		nxt_pend = '0;
		nxt_cnt  = '0;
		if (is_break) begin
			res.count = RES_CNT_W'(pend_cnt) + RES_CNT_W'(kind == KIND_DATA);
		end else if (full_match) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				res.bytes[i] = rep_bytes[8*i +: 8];
			end
			res.count = RES_CNT_W'(rlen);
		end else begin
			res.count = RES_CNT_W'(k_sel);
			nxt_pend  = shifted;
			nxt_cnt   = cnt_ext - k_sel;
		end
	end

endmodule

// ----- src/stream_find_and_replace_core.sv -----
// ----------------------------------------------------------------------------
// stream_find_and_replace_core
// Streaming find-and-replace over a byte stream. Every leftmost,
// non-overlapping occurrence of the pattern is replaced; bytes that may still
// start a match are held until they cannot; a newline or flush releases them.
// ----------------------------------------------------------------------------
//  channel      dir  handshake     payload
//  in_stream    in   valid/ready   kind, data_byte
//  out_stream   out  valid/ready   out_byte, last_of_run
//  cfg_*        in   cfg_write     cfg_index, cfg_data
//
// An accepted item is registered, resolved combinationally and its result
// bytes loaded into the output buffer, which sends one byte per cycle while
// the sink is ready. With a ready sink the input sustains one item per cycle
// while each causes at most one byte and stalls otherwise. The output buffer
// is the only point of backpressure. Reset leaves the hold buffer empty and
// needs no clearing pass.
// ----------------------------------------------------------------------------
module stream_find_and_replace_core #(
	parameter int MaxPattern = sfr_pkg::MAX_PATTERN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	sfr_in_if.sink                         in_stream,
	sfr_out_if.source                      out_stream
);
	import sfr_pkg::*;

	localparam int CntW = $clog2(MaxPattern + 1);

	logic [CFG_DATA_W-1:0]  pat_bytes_q;
	logic [LEN_W-1:0]       pat_len_q;
	logic [CFG_DATA_W-1:0]  rep_bytes_q;
	logic [LEN_W-1:0]       rep_len_q;

	logic                   valid_s1;
	logic                   kind_s1;
	byte_t                  byte_s1;

	byte_t [MaxPattern-1:0] pend_q;
	logic [CntW-1:0]        pcnt_q;

	byte_t [RES_DEPTH-1:0]  ob_bytes_q;
	logic [RES_CNT_W-1:0]   ob_left_q;

	result_t                res;
	byte_t [MaxPattern-1:0] nxt_pend;
	logic [CntW-1:0]        nxt_cnt;

	logic in_fire;
	logic out_fire;
	logic advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			pat_len_q   <= LEN_W'(1);
			rep_bytes_q <= '0;
			rep_len_q   <= LEN_W'(1);
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PATTERN_BYTES:      pat_bytes_q <= cfg_data;
				CFG_PATTERN_LENGTH:     pat_len_q   <= cfg_data[LEN_W-1:0];
				CFG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data;
				CFG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshakes. The stage moves on once the buffer is empty or sending its
	// final byte.
	assign out_fire = out_stream.valid && out_stream.ready;
	assign advance  = valid_s1 &&
		((ob_left_q == '0) || ((ob_left_q == RES_CNT_W'(1)) && out_stream.ready));
	assign in_stream.ready = !valid_s1 || advance;
	assign in_fire  = in_stream.valid && in_stream.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= in_stream.kind;
			byte_s1 <= in_stream.data_byte;
		end
	end

	sfr_match #(
		.MaxPattern (MaxPattern),
		.CntW       (CntW)
	) u_match (
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.pend      (pend_q),
		.pend_cnt  (pcnt_q),
		.pat_bytes (pat_bytes_q),
		.pat_len   (pat_len_q),
		.rep_bytes (rep_bytes_q),
		.rep_len   (rep_len_q),
		.res       (res),
		.nxt_pend  (nxt_pend),
		.nxt_cnt   (nxt_cnt)
	);

	// Hold buffer count and output byte count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q    <= '0;
			ob_left_q <= '0;
		end else if (advance) begin
			pcnt_q    <= nxt_cnt;
			ob_left_q <= res.count;
		end else if (out_fire) begin
			ob_left_q <= ob_left_q - RES_CNT_W'(1);
		end
	end

	// Held bytes and output buffer contents.
	always_ff @(posedge clk) begin
		if (advance) begin
			pend_q     <= nxt_pend;
			ob_bytes_q <= res.bytes;
		end else if (out_fire) begin
			ob_bytes_q <= ob_bytes_q >> 8;
		end
	end

	assign out_stream.valid       = (ob_left_q != '0);
	assign out_stream.out_byte    = ob_bytes_q[0];
	assign out_stream.last_of_run = (ob_left_q == RES_CNT_W'(1));

endmodule

// ----- src/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the find-and-replace core, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_byte,
	input logic out_last
);

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output payload changed while stalled");

	// The input only stalls while the output still has bytes to send.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output");

	// The bytes of one run leave without a gap.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside an output run");

	// Nothing is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind stream_find_and_replace_core sfr_checker u_sfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_stream.ready),
	.out_valid (out_stream.valid),
	.out_ready (out_stream.ready),
	.out_byte  (out_stream.out_byte),
	.out_last  (out_stream.last_of_run)
);
